/* hdl/asfm_pkg.sv */
// package for the adaptive sorted frequency model
// types, constants and state codes; no dependencies
`default_nettype none
package asfm_pkg;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int NSYM = 256;
    localparam int LIST_DEPTH = 257;
    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] ABSENT = 9'd256;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UPDATE = 1'b1;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] symbol_byte;
        logic       escape_mode;
    } t_in;

    typedef struct packed {
        logic [31:0] frequency;
        logic [31:0] cumulative_below;
        logic [31:0] range_total;
        logic        status;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAP, S_POS, S_SUM, S_CNT, S_CHK,
        S_BUB, S_SWAP, S_APP, S_MAPW, S_DONE
    } t_state;
endpackage
`default_nettype wire

/* hdl/adaptive_sorted_frequency_model_top.sv */
// adaptive sorted frequency model, top level
// depends on asfm_pkg, asfm_ram, asfm_alu
// a transaction walks the count list up to the byte's place to sum the counts below it;
//   escape and unseen bytes skip the walk; a count update then bubbles the entry forward,
//   an escape update of an unseen byte appends it; the pace is set by the list walk through
//   the count ram and the shared adder; one transaction at a time
// reset: a clearing pass marks every byte but byte 0 absent in the map, with byte 0 at
//   list entry 0 with count 1, before the first transaction is taken
`default_nettype none
module adaptive_sorted_frequency_model_top #(
    parameter int COUNT_WIDTH = asfm_pkg::COUNT_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire asfm_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output asfm_pkg::t_out       o_data
);
    localparam int CW = COUNT_WIDTH;
    localparam int PW = asfm_pkg::POS_W;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [CW-1:0] ONE = CW'(1);

    asfm_pkg::t_state r_st, n_st;
    asfm_pkg::t_in r_in, n_in;
    logic [PW-1:0] r_pos, n_pos, r_i, n_i, r_len, n_len;
    logic [CW-1:0] r_tot, n_tot, r_acc, n_acc, r_cur, n_cur;
    logic [7:0] r_oth, n_oth;
    logic r_ov, n_ov;
    asfm_pkg::t_out r_out, n_out;

    // memories
    logic m_we, c_we, s_we;
    logic [7:0] m_wa, m_ra;
    logic [PW-1:0] m_wd, m_rd;
    logic [PW-1:0] c_wa, c_ra, s_wa, s_ra;
    logic [CW-1:0] c_wd, c_rd;
    logic [7:0] s_wd, s_rd;

    asfm_ram #(.WIDTH(PW), .DEPTH(asfm_pkg::NSYM)) u_map (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));
    asfm_ram #(.WIDTH(CW), .DEPTH(asfm_pkg::LIST_DEPTH)) u_cnt (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    asfm_ram #(.WIDTH(8), .DEPTH(asfm_pkg::LIST_DEPTH)) u_sym (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));

    logic [CW-1:0] a_a, a_b, a_s;
    logic a_gt;
    asfm_alu #(.CW(CW)) u_alu (.i_a(a_a), .i_b(a_b), .o_sum(a_s), .o_gt(a_gt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= asfm_pkg::S_CLEAR;
            r_i <= '0;
            r_len <= PW'(1);
            r_tot <= ONE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_i <= n_i;
            r_len <= n_len;
            r_tot <= n_tot;
            r_ov <= n_ov;
        end
        r_in <= n_in; r_pos <= n_pos; r_acc <= n_acc; r_cur <= n_cur;
        r_oth <= n_oth; r_out <= n_out;
    end

    logic w_present;
    assign w_present = (r_pos < r_len);

    always_comb begin
        n_st = r_st; n_in = r_in; n_pos = r_pos; n_i = r_i; n_len = r_len;
        n_tot = r_tot; n_acc = r_acc; n_cur = r_cur; n_oth = r_oth;
        n_ov = r_ov; n_out = r_out;
        m_we = 1'b0; m_wa = r_in.symbol_byte; m_wd = r_pos;
        m_ra = r_in.symbol_byte;
        c_we = 1'b0; c_wa = r_i; c_wd = r_cur; c_ra = r_i;
        s_we = 1'b0; s_wa = r_i; s_wd = r_in.symbol_byte; s_ra = r_i;
        a_a = r_acc; a_b = c_rd;
        o_ready = 1'b0;
        // a waiting result leaves in any state
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            asfm_pkg::S_CLEAR: begin
                // sweep the map, list entry 0 holds byte 0 with count 1
                m_we = 1'b1; m_wa = r_i[7:0];
                m_wd = (r_i == '0) ? '0 : asfm_pkg::ABSENT;
                c_we = (r_i == '0); c_wa = '0; c_wd = ONE;
                s_we = (r_i == '0); s_wa = '0; s_wd = 8'd0;
                n_i = r_i + PW'(1);
                if (r_i == PW'(asfm_pkg::NSYM - 1)) n_st = asfm_pkg::S_IDLE;
            end
            asfm_pkg::S_IDLE: begin
                // a new transaction may start while the last result waits
                o_ready = 1'b1;
                if (i_valid) begin
                    n_in = i_data; n_st = asfm_pkg::S_MAP;
                end
            end
            asfm_pkg::S_MAP: begin
                // map read in flight
                n_st = asfm_pkg::S_POS;
            end
            asfm_pkg::S_POS: begin
                n_pos = m_rd; n_i = '0; n_acc = '0;
                c_ra = '0;
                n_st = asfm_pkg::S_SUM;
            end
            asfm_pkg::S_SUM: begin
                // running sum, one list entry per pass through S_SUM and S_CNT; c_rd holds entry r_i
                if (r_in.escape_mode || !w_present) begin
                    n_st = asfm_pkg::S_DONE;
                end else if (r_i == r_pos) begin
                    n_cur = c_rd; n_st = asfm_pkg::S_DONE;
                end else begin
                    n_acc = a_s; n_i = r_i + PW'(1); c_ra = r_i + PW'(1);
                    n_st = asfm_pkg::S_CNT;
                end
            end
            asfm_pkg::S_CNT: begin
                c_ra = r_i; n_st = asfm_pkg::S_SUM;
            end
            asfm_pkg::S_DONE: begin
                // hold here while the previous result is still waiting
                if (!r_ov || i_ready) begin
                    n_out.frequency = r_in.escape_mode ? 32'd1 :
                        (w_present ? 32'(r_cur) : 32'd0);
                    n_out.cumulative_below = r_in.escape_mode ?
                        {24'd0, r_in.symbol_byte} :
                        (w_present ? 32'(r_acc) : 32'(r_tot));
                    n_out.range_total = r_in.escape_mode ? 32'd256 : 32'(r_tot);
                    n_out.status = asfm_pkg::ST_OK;
                    n_ov = 1'b1;
                    n_st = asfm_pkg::S_IDLE;
                    if (r_in.operation == asfm_pkg::OP_UPDATE) begin
                        if (r_in.escape_mode) begin
                            if (w_present) n_out.status = asfm_pkg::ST_REFUSED;
                            else n_st = asfm_pkg::S_APP;
                        end else if (w_present) begin
                            n_cur = (r_cur == CMAX) ? CMAX : r_cur + ONE;
                            n_tot = (r_tot == CMAX) ? CMAX : r_tot + ONE;
                            n_i = r_pos;
                            n_st = asfm_pkg::S_CHK;
                        end
                    end
                end
            end
            asfm_pkg::S_APP: begin
                c_we = 1'b1; c_wa = r_len; c_wd = ONE;
                s_we = 1'b1; s_wa = r_len;
                m_we = 1'b1; m_wd = r_len;
                n_len = r_len + PW'(1);
                n_tot = (r_tot == CMAX) ? CMAX : r_tot + ONE;
                n_st = asfm_pkg::S_IDLE;
            end
            asfm_pkg::S_CHK: begin
                // write the counted entry at r_i and fetch its predecessor
                c_we = 1'b1; s_we = 1'b1;
                m_we = 1'b1; m_wd = r_i;
                c_ra = r_i - PW'(1); s_ra = r_i - PW'(1);
                n_st = (r_i == '0) ? asfm_pkg::S_IDLE : asfm_pkg::S_BUB;
            end
            asfm_pkg::S_BUB: begin
                a_a = r_cur; a_b = c_rd;
                n_acc = c_rd; n_oth = s_rd;
                n_st = a_gt ? asfm_pkg::S_SWAP : asfm_pkg::S_IDLE;
            end
            asfm_pkg::S_SWAP: begin
                // predecessor moves down one place
                c_we = 1'b1; c_wd = r_acc; s_we = 1'b1; s_wd = r_oth;
                m_we = 1'b1; m_wa = r_oth; m_wd = r_i;
                n_i = r_i - PW'(1);
                n_st = asfm_pkg::S_CHK;
            end
            default: n_st = asfm_pkg::S_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data = r_out;

    // no transaction is taken while a swap moves a list entry
    a_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == asfm_pkg::S_SWAP) |-> !o_ready) else $error("ready during swap");
    // list never exceeds its depth
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= PW'(asfm_pkg::LIST_DEPTH)) else $error("list overflow");
    // total never decreases
    a_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_tot >= $past(r_tot)) else $error("total fell");
endmodule
`default_nettype wire

/* hdl/asfm_ram.sv */
// generic ram with one write port and one registered read port
// no dependencies
`default_nettype none
module asfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/asfm_alu.sv */
// shared saturating adder and comparator of the sequencer
// depends on asfm_pkg
`default_nettype none
module asfm_alu #(
    parameter int CW = asfm_pkg::COUNT_WIDTH_DEF
) (
    input  wire [CW-1:0] i_a,
    input  wire [CW-1:0] i_b,
    output logic [CW-1:0] o_sum,
    output logic          o_gt
);
    logic [CW:0] w_s;
    assign w_s   = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = w_s[CW] ? {CW{1'b1}} : w_s[CW-1:0];
    assign o_gt  = i_a > i_b;
endmodule
`default_nettype wire

/* verif/asfm_checker.sv */
// transaction checker for the adaptive sorted frequency model
// watches both channels, predicts each result and compares; depends on asfm_pkg
`timescale 1ns / 1ps
module asfm_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  asfm_pkg::t_in        i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  asfm_pkg::t_out       i_out_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_refused
);
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    logic [7:0]  seen_syms [asfm_pkg::LIST_DEPTH];
    logic [31:0] seen_cnts [asfm_pkg::LIST_DEPTH];
    logic [8:0]  where_is [asfm_pkg::NSYM];
    int          seen_len;
    logic [31:0] total_cnt;
    asfm_pkg::t_out answers_due [$];

    function automatic logic [31:0] inc_sat(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    task automatic model_clear();
        for (int k = 0; k < asfm_pkg::NSYM; k++) where_is[k] = asfm_pkg::ABSENT;
        for (int k = 0; k < asfm_pkg::LIST_DEPTH; k++) begin
            seen_syms[k] = 8'd0;
            seen_cnts[k] = 32'd0;
        end
        where_is[0] = 9'd0;
        seen_cnts[0] = 32'd1;
        seen_len = 1;
        total_cnt = 32'd1;
    endtask

    // computes the answer for one query and applies any update
    task automatic code_symbol(input asfm_pkg::t_in txn, output asfm_pkg::t_out ans);
        int          p;
        bit          found;
        logic [32:0] acc;
        logic [7:0]  other;
        logic [31:0] tmp;
        p = int'(where_is[txn.symbol_byte]);
        found = (p < seen_len);
        ans.status = asfm_pkg::ST_OK;
        if (txn.escape_mode) begin
            ans.frequency = 32'd1;
            ans.cumulative_below = {24'd0, txn.symbol_byte};
            ans.range_total = 32'd256;
        end else if (!found) begin
            ans.frequency = 32'd0;
            ans.cumulative_below = total_cnt;
            ans.range_total = total_cnt;
        end else begin
            acc = 33'd0;
            for (int k = 0; k < p; k++) begin
                acc = acc + seen_cnts[k];
                if (acc > CNT_MAX) acc = CNT_MAX;
            end
            ans.frequency = seen_cnts[p];
            ans.cumulative_below = acc[31:0];
            ans.range_total = total_cnt;
        end
        if (txn.operation == asfm_pkg::OP_UPDATE) begin
            if (txn.escape_mode) begin
                if (found || seen_len >= asfm_pkg::LIST_DEPTH) begin
                    ans.status = asfm_pkg::ST_REFUSED;
                end else begin
                    seen_syms[seen_len] = txn.symbol_byte;
                    seen_cnts[seen_len] = 32'd1;
                    where_is[txn.symbol_byte] = seen_len[8:0];
                    seen_len++;
                    total_cnt = inc_sat(total_cnt);
                end
            end else if (found) begin
                seen_cnts[p] = inc_sat(seen_cnts[p]);
                // bubble toward the front past smaller counts
                while (p > 0 && seen_cnts[p] > seen_cnts[p-1]) begin
                    other = seen_syms[p-1];
                    tmp = seen_cnts[p-1];
                    seen_cnts[p-1] = seen_cnts[p];
                    seen_cnts[p] = tmp;
                    seen_syms[p-1] = txn.symbol_byte;
                    seen_syms[p] = other;
                    where_is[txn.symbol_byte] = 9'(p - 1);
                    where_is[other] = 9'(p);
                    p--;
                end
                total_cnt = inc_sat(total_cnt);
            end
        end
    endtask

    initial begin
        model_clear();
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_refused = 0;
    end

    always @(posedge i_clk) begin
        asfm_pkg::t_out want;
        asfm_pkg::t_out got;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                code_symbol(i_in_data, want);
                answers_due = {answers_due, want};
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                o_results++;
                if (answers_due.size() == 0) begin
                    $display("%0t unexpected result: actual %h", $time, got);
                    o_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status == asfm_pkg::ST_REFUSED) o_refused++;
                    if (got.frequency !== want.frequency) begin
                        $display("%0t frequency: expected %0d actual %0d",
                                 $time, want.frequency, got.frequency);
                        o_errors++;
                    end
                    if (got.cumulative_below !== want.cumulative_below) begin
                        $display("%0t cumulative: expected %0d actual %0d",
                                 $time, want.cumulative_below, got.cumulative_below);
                        o_errors++;
                    end
                    if (got.range_total !== want.range_total) begin
                        $display("%0t total: expected %0d actual %0d",
                                 $time, want.range_total, got.range_total);
                        o_errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t status: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end
endmodule

/* verif/testbench.sv */
// top of the testbench for the adaptive sorted frequency model
// drives stimulus and gives the verdict; depends on asfm_pkg and asfm_checker
`timescale 1ns / 1ps
module testbench;
    // one transaction can walk the whole list and then bubble an entry to the front
    localparam int CYCLE_LIMIT = 6_000_000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    asfm_pkg::t_in  in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    asfm_pkg::t_out out_data;
    int    errors, pending, results, refused;
    int    cycles = 0;
    int    sent = 0;
    int    burst_left = 0;
    bit    stalls_on = 1'b1;

    always #5 clk = ~clk;

    adaptive_sorted_frequency_model_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    asfm_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_refused   (refused)
    );

    // watchdog against a hung handshake
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: long stretches of always-ready, then choppy phases
    always @(negedge clk) begin
        if ($urandom_range(0, 199) == 0) stalls_on = ~stalls_on;
        out_ready <= stalls_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // present one transaction, then hold it until accepted; a gap may follow
    task automatic send_txn(input logic op, input logic [7:0] sym, input logic esc);
        int gap;
        in_data <= '{operation: op, symbol_byte: sym, escape_mode: esc};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: random gap, then a new burst length
            in_valid <= 1'b0;
            gap = $urandom_range(0, 6);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // hold off until the block has answered everything
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    int   sym;
    logic op;
    logic esc;

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: initial state, escape extremes, refused append, counted bytes
        send_txn(asfm_pkg::OP_QUERY, 8'd0, 1'b0);
        send_txn(asfm_pkg::OP_QUERY, 8'd255, 1'b0);
        send_txn(asfm_pkg::OP_UPDATE, 8'd255, 1'b0);      // unseen byte, nothing counted
        send_txn(asfm_pkg::OP_QUERY, 8'd255, 1'b1);
        send_txn(asfm_pkg::OP_UPDATE, 8'd255, 1'b1);      // append
        send_txn(asfm_pkg::OP_UPDATE, 8'd255, 1'b1);      // refused, already present
        send_txn(asfm_pkg::OP_UPDATE, 8'd0, 1'b1);        // refused, byte 0 present at reset
        send_txn(asfm_pkg::OP_UPDATE, 8'hAA, 1'b1);
        send_txn(asfm_pkg::OP_UPDATE, 8'h55, 1'b1);
        send_txn(asfm_pkg::OP_UPDATE, 8'h55, 1'b0);       // bubbles forward
        send_txn(asfm_pkg::OP_UPDATE, 8'h55, 1'b0);
        send_txn(asfm_pkg::OP_UPDATE, 8'h55, 1'b0);
        send_txn(asfm_pkg::OP_QUERY, 8'hAA, 1'b0);
        send_txn(asfm_pkg::OP_QUERY, 8'h55, 1'b0);
        send_txn(asfm_pkg::OP_UPDATE, 8'd255, 1'b0);
        send_txn(asfm_pkg::OP_QUERY, 8'd255, 1'b0);
        send_txn(asfm_pkg::OP_QUERY, 8'd0, 1'b1);
        drain();

        // random: mostly updates, one in four transactions escaped, half the bytes from 0 to 15
        for (int n = 0; n < 750; n++) begin
            if (n == 375) drain();
            op = ($urandom_range(0, 3) != 0) ? asfm_pkg::OP_UPDATE : asfm_pkg::OP_QUERY;
            esc = ($urandom_range(0, 3) == 0);
            sym = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
            send_txn(op, sym[7:0], esc);
        end
        drain();
        in_valid <= 1'b0;
        repeat (1500) @(negedge clk);

        $display("sent %0d transactions, checked %0d results, %0d refused appends",
                 sent, results, refused);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* sim.f */
hdl/asfm_pkg.sv
hdl/asfm_ram.sv
hdl/asfm_alu.sv
hdl/adaptive_sorted_frequency_model_top.sv
verif/asfm_checker.sv
verif/testbench.sv
